/* sv/ngh_pkg.sv */
`default_nettype none
package ngh_pkg;

   // shared multiplier operand and accumulator widths
   localparam int MW = 33;
   localparam int PW = 2 * MW;

   localparam logic [16:0] GAIN_ONE = 17'd65536;

   typedef enum logic [2:0] {
      CSR_OPEN_LEVEL_SQ   = 3'd0,
      CSR_CLOSE_LEVEL_SQ  = 3'd1,
      CSR_HOLD_SAMPLES    = 3'd2,
      CSR_GAIN_ATTACK     = 3'd3,
      CSR_GAIN_RELEASE    = 3'd4,
      CSR_FLOOR_GAIN      = 3'd5,
      CSR_PEAK_ATTACK     = 3'd6,
      CSR_PEAK_RELEASE    = 3'd7
   } csr_index_type;

   localparam logic [1:0] GATE_CLOSED = 2'd0;
   localparam logic [1:0] GATE_OPEN   = 2'd1;
   localparam logic [1:0] GATE_HOLD   = 2'd2;

   typedef struct packed {
      logic                 restart;
      logic signed [MW-1:0] op_a;
      logic signed [MW-1:0] op_b;
      logic signed [PW-1:0] bias;
   } mac_req_type;

endpackage
`default_nettype wire

/* sv/ngh_mac.sv */
`default_nettype none
module ngh_mac (
   input  logic                          clock,
   input  ngh_pkg::mac_req_type          mac_req,
   output logic signed [ngh_pkg::PW-1:0] mac_sum
);
   import ngh_pkg::*;

   logic signed [PW-1:0] acc_ff;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] base;

   assign prod    = PW'(mac_req.op_a) * PW'(mac_req.op_b);
   assign base    = mac_req.restart ? mac_req.bias : acc_ff;
   assign mac_sum = base + prod;

   always_ff @(posedge clock) begin
      acc_ff <= mac_sum;
   end

endmodule
`default_nettype wire

/* sv/noise_gate_hold_hysteresis_top.sv */
// Stereo noise gate with peak / mean-square detector, hold and hysteresis.
// req_ channel: one request carries a stereo audio frame and its filtered
// sidechain pair. rsp_ channel: one response per request with both gated
// samples, the smoothed gain and the gate mode after that frame.
// csr_ port: register writes, accepted at any time; write only while no
// request is in flight.
// The response is registered once the sequencer has run all its steps.
// A request is taken only while idle. All multiplies go through one
// shared 33x33 multiply-accumulate unit, one product per cycle, and the
// sequencer walks peak, square, mean square, level, gate, gain and the two
// output products in turn.
// A finished response sits in the output register; the next request is
// already accepted meanwhile. If the receiver still stalls when the next
// response is ready, the sequencer waits in its last step until the output
// register frees up.
// Reset (synchronous) loads the register defaults, clears the detector,
// closes the gate and sets the gain to unity; no response is pending.
`default_nettype none
module noise_gate_hold_hysteresis_top #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEFF_BITS  = 16,
   parameter int RMS_COEFF   = 32632
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // audio_left, audio_right, side_left, side_right
   input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // gated_left, gated_right, gain_now, gate_mode
   output logic [((2*SAMPLE_BITS+19+7)/8)*8-1:0]    rsp_tdata,
   input  logic                                    csr_we,
   input  logic [2:0]                              csr_index,
   input  logic [31:0]                             csr_wdata
);
   import ngh_pkg::*;

   localparam int SB      = SAMPLE_BITS;
   localparam int PKW     = SB - 1;
   localparam int RSP_W   = ((2*SB+19+7)/8)*8;
   localparam int RSP_PAD = RSP_W - (2*SB + 19);
   localparam int SQ_RSH  = (2*SB - 34) > 0 ? (2*SB - 34) : 0;
   localparam int SQ_LSH  = (34 - 2*SB) > 0 ? (34 - 2*SB) : 0;
   localparam int CUSE    = COEFF_BITS < 16 ? COEFF_BITS : 16;

   localparam logic signed [MW-1:0] CONE_M =
      {{(MW-COEFF_BITS-1){1'b0}}, 1'b1, {COEFF_BITS{1'b0}}};
   localparam logic signed [PW-1:0] CHALF =
      {{(PW-COEFF_BITS){1'b0}}, 1'b1, {(COEFF_BITS-1){1'b0}}};
   localparam logic signed [MW-1:0] RMS_A = MW'(RMS_COEFF);
   localparam logic signed [MW-1:0] RMS_B = MW'(32768 - RMS_COEFF);
   localparam logic signed [PW-1:0] RMS_HALF  = PW'(16384);
   localparam logic signed [PW-1:0] OUT_HALF  = PW'(32768);
   localparam logic signed [PW-1:0] SMAX_W    = {{(PW-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic signed [PW-1:0] SMIN_W    = -SMAX_W - PW'(1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PEAK0, ST_PEAK1, ST_SQ, ST_MS0, ST_MS1, ST_PK2,
      ST_GATE, ST_G0, ST_G1, ST_OUTL, ST_OUTR
   } state_type;

   function automatic logic [31:0] to_q32(input logic signed [PW-1:0] v);
      logic [PW-1:0] s;
      s = (PW'($unsigned(v)) >> SQ_RSH) << SQ_LSH;
      return (|s[PW-1:32]) ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [SB-1:0] sat_sample(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      t = v >>> 16;
      if (t > SMAX_W) begin
         t = SMAX_W;
      end else if (t < SMIN_W) begin
         t = SMIN_W;
      end
      return t[SB-1:0];
   endfunction

   // registers
   logic [31:0] open_sq_ff, close_sq_ff;
   logic [16:0] hold_samples_ff, floor_ff;
   logic [15:0] g_att_ff, g_rel_ff, p_att_ff, p_rel_ff;

   state_type   state_ff;
   logic [PKW-1:0] peak_ff, rect_ff;
   logic [31:0] ms_ff, sq_ff, level_ff;
   logic [1:0]  phase_ff;
   logic [16:0] hold_ff, gain_ff, target_ff;
   logic        gup_ff;
   logic [SB-1:0] al_ff, ar_ff, gl_ff;
   logic        rsp_valid_ff;
   logic [SB-1:0] rsp_gl_ff, rsp_gr_ff;
   logic [16:0] rsp_gain_ff;
   logic [1:0]  rsp_mode_ff;

   // next values
   logic [PKW-1:0] rect_in, peak_in;
   logic [31:0] sq_in, ms_in, level_in;
   logic [1:0]  phase_in;
   logic [16:0] hold_in, target_in, gain_in;
   logic        gup_in;
   logic [SB-1:0] gl_in, gr_in;

   logic signed [SB:0] side_sum;
   logic [SB:0]        side_mag;
   logic [31:0]        pk2;
   logic signed [PW-1:0] t_ms, t_gain;
   logic [16:0]        floor_lim;
   logic [MW-1:0]      c_peak, c_gain;
   logic               req_fire, out_free;

   mac_req_type          mac_req;
   logic signed [PW-1:0] mac_sum;

   ngh_mac u_mac (
      .clock   (clock),
      .mac_req (mac_req),
      .mac_sum (mac_sum)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_mode_ff, rsp_gain_ff, rsp_gr_ff, rsp_gl_ff};

   // rectified sidechain mean
   always_comb begin
      side_sum = $signed({req_tdata[3*SB-1], req_tdata[3*SB-1:2*SB]})
               + $signed({req_tdata[4*SB-1], req_tdata[4*SB-1:3*SB]});
      side_mag = side_sum[SB] ? (SB+1)'(-side_sum) : $unsigned(side_sum);
      rect_in  = side_mag[SB] ? {PKW{1'b1}} : side_mag[SB-1:1];
   end

   assign c_peak = (rect_ff > peak_ff) ? MW'(p_att_ff[CUSE-1:0]) : MW'(p_rel_ff[CUSE-1:0]);
   assign c_gain = gup_ff ? MW'(g_att_ff[CUSE-1:0]) : MW'(g_rel_ff[CUSE-1:0]);

   // shared unit operand select
   always_comb begin
      mac_req.restart = 1'b1;
      mac_req.op_a    = '0;
      mac_req.op_b    = '0;
      mac_req.bias    = '0;
      case (state_ff)
         ST_PEAK0: begin
            mac_req.op_a = $signed(c_peak);
            mac_req.op_b = $signed(MW'(peak_ff));
            mac_req.bias = CHALF;
         end
         ST_PEAK1: begin
            mac_req.restart = 1'b0;
            mac_req.op_a    = CONE_M - $signed(c_peak);
            mac_req.op_b    = $signed(MW'(rect_ff));
         end
         ST_SQ: begin
            mac_req.op_a = $signed(MW'(rect_ff));
            mac_req.op_b = $signed(MW'(rect_ff));
         end
         ST_MS0: begin
            mac_req.op_a = RMS_A;
            mac_req.op_b = $signed(MW'(ms_ff));
            mac_req.bias = RMS_HALF;
         end
         ST_MS1: begin
            mac_req.restart = 1'b0;
            mac_req.op_a    = RMS_B;
            mac_req.op_b    = $signed(MW'(sq_ff));
         end
         ST_PK2: begin
            mac_req.op_a = $signed(MW'(peak_ff));
            mac_req.op_b = $signed(MW'(peak_ff));
         end
         ST_G0: begin
            mac_req.op_a = $signed(c_gain);
            mac_req.op_b = $signed(MW'(gain_ff));
            mac_req.bias = CHALF;
         end
         ST_G1: begin
            mac_req.restart = 1'b0;
            mac_req.op_a    = CONE_M - $signed(c_gain);
            mac_req.op_b    = $signed(MW'(target_ff));
         end
         ST_OUTL: begin
            mac_req.op_a = $signed({{(MW-SB){al_ff[SB-1]}}, al_ff});
            mac_req.op_b = $signed(MW'(gain_ff));
            mac_req.bias = OUT_HALF;
         end
         ST_OUTR: begin
            mac_req.op_a = $signed({{(MW-SB){ar_ff[SB-1]}}, ar_ff});
            mac_req.op_b = $signed(MW'(gain_ff));
            mac_req.bias = OUT_HALF;
         end
         default: begin
            mac_req.restart = 1'b1;
         end
      endcase
   end

   // step results
   always_comb begin
      peak_in  = PKW'(mac_sum >>> COEFF_BITS);
      sq_in    = to_q32(mac_sum);
      t_ms     = mac_sum >>> 15;
      ms_in    = (|t_ms[PW-1:32]) ? 32'hFFFF_FFFF : t_ms[31:0];
      pk2      = to_q32(mac_sum);
      level_in = (pk2 > ms_ff) ? pk2 : ms_ff;
      t_gain   = mac_sum >>> COEFF_BITS;
      gain_in  = (t_gain > $signed(PW'(GAIN_ONE))) ? GAIN_ONE : t_gain[16:0];
      gl_in    = sat_sample(mac_sum);
      gr_in    = sat_sample(mac_sum);
   end

   // gate phase, hold count and gain target
   always_comb begin
      phase_in = phase_ff;
      hold_in  = hold_ff;
      case (phase_ff)
         GATE_OPEN: begin
            if (level_ff < close_sq_ff) begin
               phase_in = GATE_HOLD;
               hold_in  = hold_samples_ff;
            end
         end
         GATE_HOLD: begin
            if (level_ff > open_sq_ff) begin
               phase_in = GATE_OPEN;
            end else if (hold_ff <= 17'd1) begin
               phase_in = GATE_CLOSED;
               hold_in  = '0;
            end else begin
               hold_in = hold_ff - 17'd1;
            end
         end
         default: begin
            phase_in = (level_ff > open_sq_ff) ? GATE_OPEN : GATE_CLOSED;
         end
      endcase
      floor_lim = (floor_ff > GAIN_ONE) ? GAIN_ONE : floor_ff;
      target_in = (phase_in == GATE_CLOSED) ? floor_lim : GAIN_ONE;
      gup_in    = target_in > gain_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_sq_ff      <= 32'd135812;
         close_sq_ff     <= 32'd54067;
         hold_samples_ff <= 17'd1920;
         g_att_ff        <= 16'd62861;
         g_rel_ff        <= 16'd65525;
         floor_ff        <= 17'd66;
         p_att_ff        <= 16'd53208;
         p_rel_ff        <= 16'd65400;
         state_ff        <= ST_IDLE;
         peak_ff         <= '0;
         ms_ff           <= '0;
         phase_ff        <= GATE_CLOSED;
         hold_ff         <= '0;
         gain_ff         <= GAIN_ONE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OPEN_LEVEL_SQ:  open_sq_ff      <= csr_wdata;
               CSR_CLOSE_LEVEL_SQ: close_sq_ff     <= csr_wdata;
               CSR_HOLD_SAMPLES:   hold_samples_ff <= csr_wdata[16:0];
               CSR_GAIN_ATTACK:    g_att_ff        <= csr_wdata[15:0];
               CSR_GAIN_RELEASE:   g_rel_ff        <= csr_wdata[15:0];
               CSR_FLOOR_GAIN:     floor_ff        <= csr_wdata[16:0];
               CSR_PEAK_ATTACK:    p_att_ff        <= csr_wdata[15:0];
               CSR_PEAK_RELEASE:   p_rel_ff        <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && state_ff != ST_OUTR) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  rect_ff  <= rect_in;
                  al_ff    <= req_tdata[SB-1:0];
                  ar_ff    <= req_tdata[2*SB-1:SB];
                  state_ff <= ST_PEAK0;
               end
            end
            ST_PEAK0: state_ff <= ST_PEAK1;
            ST_PEAK1: begin
               peak_ff  <= peak_in;
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               sq_ff    <= sq_in;
               state_ff <= ST_MS0;
            end
            ST_MS0: state_ff <= ST_MS1;
            ST_MS1: begin
               ms_ff    <= ms_in;
               state_ff <= ST_PK2;
            end
            ST_PK2: begin
               level_ff <= level_in;
               state_ff <= ST_GATE;
            end
            ST_GATE: begin
               phase_ff  <= phase_in;
               hold_ff   <= hold_in;
               target_ff <= target_in;
               gup_ff    <= gup_in;
               state_ff  <= ST_G0;
            end
            ST_G0: state_ff <= ST_G1;
            ST_G1: begin
               gain_ff  <= gain_in;
               state_ff <= ST_OUTL;
            end
            ST_OUTL: begin
               gl_ff    <= gl_in;
               state_ff <= ST_OUTR;
            end
            ST_OUTR: begin
               // output register is free or drains this cycle
               if (out_free) begin
                  rsp_gl_ff    <= gl_ff;
                  rsp_gr_ff    <= gr_in;
                  rsp_gain_ff  <= gain_ff;
                  rsp_mode_ff  <= phase_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire
